// File: sv/assert_macros.svh
// Assertion macros shared by the sliding window min/max RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed in sliding window min/max");
// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed in sliding window min/max");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_ALWAYS(label, clk, prop)
`endif
`endif

// File: sv/swmm_pkg.sv
// Package with types, codes and helpers of the sliding window min/max block.
package swmm_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int WIN_LEN_W    = 7;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 7;
    localparam int MAX_WINDOW_DEFAULT = 64;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LEN   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_EXTREME_MODE = CFG_INDEX_W'(1);

    localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RESET = WIN_LEN_W'(1);

    // Ring operations, applied to every cell in the same cycle.
    typedef logic [1:0] t_ring_op;
    localparam t_ring_op RING_HOLD   = 2'd0;
    localparam t_ring_op RING_ROTATE = 2'd1;
    localparam t_ring_op RING_INSERT = 2'd2;

    typedef struct packed {
        t_ring_op op;
    } t_ring_ctl;

    // True when cand beats cur: lower in mode 0, higher in mode 1.
    function automatic logic better(input t_sample cand, input t_sample cur,
                                    input logic mode);
        better = mode ? (cand > cur) : (cand < cur);
    endfunction

endpackage

// File: sv/swmm_if.sv
// Channel interfaces: sample input, result output and configuration write.
interface swmm_in_if;
    logic               valid;
    logic               ready;
    swmm_pkg::t_sample  sample;
    logic               series_start;

    modport source (output valid, output sample, output series_start, input ready);
    modport sink   (input valid, input sample, input series_start, output ready);
endinterface

interface swmm_out_if;
    logic               valid;
    logic               ready;
    swmm_pkg::t_sample  extreme;
    logic               window_full;

    modport source (output valid, output extreme, output window_full, input ready);
    modport sink   (input valid, input extreme, input window_full, output ready);
endinterface

interface swmm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [swmm_pkg::CFG_INDEX_W-1:0]   index;
    logic [swmm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/sliding_window_min_max.sv
// Top level of the sliding window minimum / maximum block.
//
//  Channel  Direction  Payload                     Transfer when
//  i_in     in         sample, series_start        valid && ready
//  o_out    out        extreme, window_full        valid && ready
//  i_cfg    in         index, data                 valid && ready (ready is always 1)
//
//  An item goes from idle straight to done when no history is looked at (window_len
//  0 or 1, or the first sample of a series), and otherwise through a scan in which the
//  ring of MAX_WINDOW - 1 history cells makes one full revolution past the comparator.
//  A new sample is taken only while the block is idle; a finished result waits in
//  the output register, and a stalled output holds the block before the ring update.
//  Reset is synchronous and active low; it clears control state and starts a new
//  series. The history cells have no reset and are read only after being written.
module sliding_window_min_max #(
    parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swmm_in_if.sink      i_in,
    swmm_out_if.source   o_out,
    swmm_cfg_if.sink     i_cfg
);

`include "assert_macros.svh"

    // Number of history cells and widths that follow from it.
    localparam int DEPTH = MAX_WINDOW - 1;
    localparam int CW    = $clog2(MAX_WINDOW);
    localparam int NW    = ($clog2(MAX_WINDOW + 1) > swmm_pkg::WIN_LEN_W) ?
                           $clog2(MAX_WINDOW + 1) : swmm_pkg::WIN_LEN_W;

    // Controller states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Configuration registers.
    logic [swmm_pkg::WIN_LEN_W-1:0] r_window_len;
    logic                           r_mode;

    // Controller and per-series state.
    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_fill, n_fill;
    logic [CW-1:0]      r_look, n_look;
    logic [CW-1:0]      r_step, n_step;
    logic               r_item_mode, n_item_mode;
    logic               r_whole, n_whole;
    logic               r_full, n_full;
    swmm_pkg::t_sample  r_cand, n_cand;
    swmm_pkg::t_sample  r_best, n_best;
    swmm_pkg::t_sample  r_sext, n_sext;

    // Output register.
    logic               r_out_valid, n_out_valid;
    swmm_pkg::t_sample  r_extreme, n_extreme;
    logic               r_window_full, n_window_full;

    swmm_pkg::t_ring_ctl ring_ctl;
    swmm_pkg::t_sample   cell_value [DEPTH];

    logic               in_xfer;
    logic               out_free;
    logic [CW-1:0]      fill_eff;
    logic [NW-1:0]      len_ext;
    logic [NW-1:0]      len_clamped;
    logic [NW-1:0]      look_len;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= swmm_pkg::WINDOW_LEN_RESET;
            r_mode       <= 1'b0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == swmm_pkg::CFG_WINDOW_LEN) begin
                r_window_len <= i_cfg.data[swmm_pkg::WIN_LEN_W-1:0];
            end else if (i_cfg.index == swmm_pkg::CFG_EXTREME_MODE) begin
                r_mode <= i_cfg.data[0];
            end
        end
    end

    // The ring is a chain of cells: cell 0 holds the newest past sample. A rotation
    // moves every sample one cell toward cell 0, with cell 0 wrapping to the far end,
    // so after DEPTH rotations the ring is back in order. An insert shifts the new
    // sample into cell 0 and drops the oldest.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        swmm_pkg::t_sample from_prev;
        swmm_pkg::t_sample from_next;
        if (k == 0) begin : g_head
            assign from_prev = r_cand;
        end else begin : g_body
            assign from_prev = cell_value[k-1];
        end
        if (k == DEPTH - 1) begin : g_tail
            assign from_next = cell_value[0];
        end else begin : g_mid
            assign from_next = cell_value[k+1];
        end
        swmm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ring_ctl),
            .i_from_prev (from_prev),
            .i_from_next (from_next),
            .o_value     (cell_value[k])
        );
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign in_xfer       = i_in.valid && i_in.ready;
    assign out_free      = !r_out_valid || o_out.ready;

    // A flagged sample starts a new series with no past samples.
    assign fill_eff    = i_in.series_start ? '0 : r_fill;
    assign len_ext     = NW'(r_window_len);
    assign len_clamped = (len_ext > NW'(MAX_WINDOW)) ? NW'(MAX_WINDOW) : len_ext;
    assign look_len    = (len_clamped == '0) ? '0 : len_clamped - NW'(1);

    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_look        = r_look;
        n_step        = r_step;
        n_item_mode   = r_item_mode;
        n_whole       = r_whole;
        n_full        = r_full;
        n_cand        = r_cand;
        n_best        = r_best;
        n_sext        = r_sext;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_extreme     = r_extreme;
        n_window_full = r_window_full;
        ring_ctl.op   = swmm_pkg::RING_HOLD;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cand      = i_in.sample;
                    n_best      = i_in.sample;
                    n_item_mode = r_mode;
                    n_whole     = (len_clamped == '0);
                    n_full      = (len_clamped == '0) ||
                                  (NW'(fill_eff) + NW'(1) >= len_clamped);
                    n_look      = (look_len > NW'(fill_eff)) ? fill_eff : CW'(look_len);
                    n_step      = '0;
                    n_fill      = (fill_eff == CW'(DEPTH)) ? fill_eff : fill_eff + CW'(1);
                    if (fill_eff == '0 ||
                        swmm_pkg::better(i_in.sample, r_sext, r_mode)) begin
                        n_sext = i_in.sample;
                    end
                    // Nothing to look at: the ring need not turn.
                    if ((len_clamped == '0) || (n_look == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Cell 0 holds the sample of age r_step + 1 in this cycle.
                ring_ctl.op = swmm_pkg::RING_ROTATE;
                if (r_step < r_look &&
                    swmm_pkg::better(cell_value[0], r_best, r_item_mode)) begin
                    n_best = cell_value[0];
                end
                n_step = r_step + CW'(1);
                if (r_step == CW'(DEPTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    ring_ctl.op   = swmm_pkg::RING_INSERT;
                    n_out_valid   = 1'b1;
                    n_extreme     = r_whole ? r_sext : r_best;
                    n_window_full = r_full;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_sext      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_sext      <= n_sext;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_look        <= n_look;
        r_step        <= n_step;
        r_item_mode   <= n_item_mode;
        r_whole       <= n_whole;
        r_full        <= n_full;
        r_cand        <= n_cand;
        r_best        <= n_best;
        r_extreme     <= n_extreme;
        r_window_full <= n_window_full;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.extreme     = r_extreme;
    assign o_out.window_full = r_window_full;

    `ASSERT_CLK(a_accept_leaves_idle, i_clk, i_rst_n,
        in_xfer |=> (r_state == S_SCAN || r_state == S_DONE))
    `ASSERT_CLK(a_scan_ends_after_revolution, i_clk, i_rst_n,
        (r_state == S_SCAN && r_step == CW'(DEPTH - 1)) |=> (r_state == S_DONE))
    `ASSERT_CLK(a_look_within_fill, i_clk, i_rst_n,
        (r_state != S_IDLE) |-> (r_look <= r_fill))
    `ASSERT_CLK(a_done_waits_for_output, i_clk, i_rst_n,
        (r_state == S_DONE && r_out_valid && !o_out.ready) |=> (r_state == S_DONE))
    `ASSERT_CLK(a_fill_bounded, i_clk, i_rst_n,
        r_fill <= CW'(DEPTH))

endmodule

// File: sv/swmm_cell.sv
// One history cell of the sample ring: holds, rotates or shifts in a sample.
module swmm_cell (
    input  logic                i_clk,
    input  swmm_pkg::t_ring_ctl i_ctl,
    input  swmm_pkg::t_sample   i_from_prev,
    input  swmm_pkg::t_sample   i_from_next,
    output swmm_pkg::t_sample   o_value
);

    swmm_pkg::t_sample r_value;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            swmm_pkg::RING_ROTATE: r_value <= i_from_next;
            swmm_pkg::RING_INSERT: r_value <= i_from_prev;
            default:               r_value <= r_value;
        endcase
    end

    assign o_value = r_value;

endmodule

// File: tb/swmm_checker.sv
// Result checker for the sliding window min/max block: predicts every result and compares.
module swmm_checker #(
    parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    swmm_in_if      i_in_ch,
    swmm_out_if     i_out_ch,
    swmm_cfg_if     i_cfg_ch,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import swmm_pkg::*;

    localparam int HIST_DEPTH   = MAX_WINDOW - 1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_sample    extreme;
        logic       window_full;
    } t_window_result;

    // Shadow copy of the registers and of the block's series state.
    logic [WIN_LEN_W-1:0]   window_len;
    logic                   extreme_mode;
    t_sample                past_samples [HIST_DEPTH];
    int unsigned            fill_count;
    int unsigned            write_slot;
    t_sample                series_extreme;

    t_window_result         expected_results [$];
    int                     fail_count;
    int                     checked_count;

    // Signed compare under the selected mode: lower wins in mode 0, higher in mode 1.
    function automatic logic outranks(input t_sample cand, input t_sample cur);
        return extreme_mode ? (cand > cur) : (cand < cur);
    endfunction

    // Advances the shadow state by one sample and returns the result it must produce.
    function automatic t_window_result predict_window(input t_sample value, input logic first);
        t_window_result res;
        int unsigned    span;
        int unsigned    look;
        int unsigned    pos;
        int unsigned    i;
        if (first) begin
            fill_count = 0;
            write_slot = 0;
        end
        if (fill_count == 0 || outranks(value, series_extreme))
            series_extreme = value;
        if (window_len == '0) begin
            res.extreme     = series_extreme;
            res.window_full = 1'b1;
        end else begin
            span = (window_len > MAX_WINDOW) ? MAX_WINDOW : window_len;
            look = (span - 1 > fill_count) ? fill_count : span - 1;
            res.extreme = value;
            pos = write_slot;
            for (i = 0; i < look; i++) begin
                pos = (pos == 0) ? HIST_DEPTH - 1 : pos - 1;
                if (outranks(past_samples[pos], res.extreme))
                    res.extreme = past_samples[pos];
            end
            res.window_full = (fill_count + 1 >= span);
        end
        past_samples[write_slot] = value;
        write_slot = (write_slot + 1 >= HIST_DEPTH) ? 0 : write_slot + 1;
        if (fill_count < HIST_DEPTH)
            fill_count++;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_window_result got;
        t_window_result want;
        if (!i_rst_n) begin
            window_len     = WINDOW_LEN_RESET;
            extreme_mode   = 1'b0;
            fill_count     = 0;
            write_slot     = 0;
            series_extreme = '0;
            fail_count     = 0;
            checked_count  = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                case (i_cfg_ch.index)
                    CFG_WINDOW_LEN:   window_len   = i_cfg_ch.data;
                    CFG_EXTREME_MODE: extreme_mode = i_cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.extreme     = i_out_ch.extreme;
                got.window_full = i_out_ch.window_full;
                checked_count++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result %0d arrived with no sample waiting: extreme %0d full %0b",
                                 checked_count, $signed(got.extreme), got.window_full);
                end else begin
                    want = expected_results.pop_front();
                    if (got.extreme !== want.extreme || got.window_full !== want.window_full) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("result %0d: extreme expected %0d got %0d, full expected %0b got %0b",
                                     checked_count, $signed(want.extreme), $signed(got.extreme),
                                     want.window_full, got.window_full);
                    end
                end
            end
            if (i_in_ch.valid && i_in_ch.ready)
                expected_results.push_back(predict_window(i_in_ch.sample, i_in_ch.series_start));
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
        o_checked    <= checked_count;
    end

endmodule

// File: tb/testbench.sv
// Testbench top for the sliding window min/max block: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import swmm_pkg::*;

    localparam int MAX_WINDOW    = MAX_WINDOW_DEFAULT;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int GAP_MAX       = 10;
    localparam int RANDOM_ITEMS  = 400;
    // Length of the one long receiver stall, enough to back the block up into its input.
    localparam int HOLD_CYCLES   = 300;
    // Register writes wait a few cycles once the last result is in, as a margin.
    localparam int SETTLE_CYCLES = 4;
    // Tail after the drain, long enough to cover two items with history.
    localparam int TAIL_CYCLES   = 2 * MAX_WINDOW + 10;
    // The longest quiet stretch of a correct run is the long stall plus one slow item
    // and a gap on each side; the limit is several times that.
    localparam int WATCHDOG_LIMIT = 2000;

    localparam t_sample SAMPLE_MIN = 32'sh8000_0000;
    localparam t_sample SAMPLE_MAX = 32'sh7fff_ffff;

    logic   i_clk = 1'b0;
    logic   i_rst_n;

    swmm_in_if  in_ch ();
    swmm_out_if out_ch ();
    swmm_cfg_if cfg_ch ();

    int     fail_count;
    int     pending_count;
    int     checked_count;

    // Stimulus knobs for the sender and the receiver processes.
    bit     in_fast      = 1'b0;
    bit     out_fast     = 1'b0;
    bit     hold_request = 1'b0;

    int     sent_count      = 0;
    int     start_count     = 0;
    int     cfg_write_count = 0;

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    sliding_window_min_max #(
        .MAX_WINDOW (MAX_WINDOW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // The checker only watches the three channels; it owns prediction and comparison.
    swmm_checker #(
        .MAX_WINDOW (MAX_WINDOW)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_ch     (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    // Random words in four picks of ten; the rest are the two extremes and small values,
    // so that ties and near ties reach the comparator often.
    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return $urandom_range(0, 1) ? t_sample'(0) : t_sample'(-1);
            3, 4, 5: return t_sample'(int'($urandom_range(0, 200)) - 100);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Window lengths: whole series, pass-through, the edges of the ring, lengths beyond
    // MAX_WINDOW (which act as MAX_WINDOW) and a spread of short windows.
    function automatic logic [CFG_DATA_W-1:0] pick_window();
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_W'(0);
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(2);
            3:       return CFG_DATA_W'(MAX_WINDOW - 1);
            4:       return CFG_DATA_W'(MAX_WINDOW);
            5:       return CFG_DATA_W'($urandom_range(MAX_WINDOW + 1, 127));
            6:       return CFG_DATA_W'(127);
            default: return CFG_DATA_W'($urandom_range(3, 16));
        endcase
    endfunction

    // Offers one sample and returns at the edge where it transfers. With no gap the
    // valid stays high from the previous transfer, so it is never dropped and raised
    // in the same step.
    task automatic send_sample(input t_sample value, input logic first);
        int gap;
        gap = in_fast ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample       <= value;
        in_ch.series_start <= first;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_count++;
        if (first)
            start_count++;
    endtask

    // Stops offering samples and waits until every expected result has come back.
    // The first edge lets the checker count the sample that transferred last.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        cfg_write_count++;
    endtask

    // Registers change only while the block is idle: every phase starts with the sender
    // paused until all results are in. A phase that does not raise series_start keeps
    // the previous series going, so a mode switch lands in the middle of a series.
    task automatic set_phase(input logic [CFG_DATA_W-1:0] window,
                             input logic [CFG_DATA_W-1:0] mode_word);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_WINDOW_LEN, window);
        write_reg(CFG_EXTREME_MODE, mode_word);
    endtask

    initial begin : stimulus
        int     random_sent;
        int     phase_count;
        int     phase_len;
        int     k;
        bit     long_run;
        logic   first;

        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sample       <= '0;
        in_ch.series_start <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_WINDOW_LEN;
        cfg_ch.data        <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings give a window of one sample in lowest-value mode, so the block
        // passes samples through. The very first sample carries no start flag and must
        // still open a series.
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(t_sample'(0), 1'b0);
        send_sample(t_sample'(-1), 1'b0);

        // Window of three in highest-value mode, with a fresh series in the middle that
        // must forget the large values before it.
        set_phase(CFG_DATA_W'(3), CFG_DATA_W'(1));
        send_sample(t_sample'(5), 1'b1);
        send_sample(t_sample'(-7), 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(t_sample'(2), 1'b1);
        send_sample(t_sample'(2), 1'b0);

        // Same series, now lowest-value mode over the history already stored.
        set_phase(CFG_DATA_W'(3), CFG_DATA_W'(0));
        send_sample(t_sample'(9), 1'b0);
        send_sample(t_sample'(-1), 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);

        // Whole-series tracking: the full flag stays high and a start resets the extreme.
        set_phase(CFG_DATA_W'(0), CFG_DATA_W'(0));
        send_sample(t_sample'(40), 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(t_sample'(-3), 1'b0);
        send_sample(t_sample'(100), 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);

        // Switching to highest value keeps the running extreme from the lowest-value
        // steps, so it now holds a mix of both modes.
        set_phase(CFG_DATA_W'(0), CFG_DATA_W'(1));
        send_sample(t_sample'(-50), 1'b0);
        send_sample(t_sample'(7), 1'b0);

        // A window length beyond MAX_WINDOW acts as MAX_WINDOW.
        set_phase(CFG_DATA_W'(127), CFG_DATA_W'(1));
        send_sample(t_sample'(1), 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(t_sample'(3), 1'b0);

        // Random phases. Most are short series; about one in six is a single long series
        // that fills and wraps the ring. The first phase runs the sender flat out while
        // the receiver holds off, so the block backs up and stalls its input.
        random_sent = 0;
        phase_count = 0;
        while (random_sent < RANDOM_ITEMS) begin
            set_phase(pick_window(), CFG_DATA_W'($urandom_range(0, 127)));
            long_run  = ($urandom_range(0, 5) == 0);
            phase_len = long_run ? $urandom_range(64, 130) : $urandom_range(4, 30);
            in_fast   = ($urandom_range(0, 3) == 0);
            if (phase_count == 0) begin
                hold_request = 1'b1;
                in_fast      = 1'b1;
                phase_len    = 12;
            end
            for (k = 0; k < phase_len; k++) begin
                if (long_run)
                    first = (k == 0);
                else
                    first = (k == 0 && $urandom_range(0, 1) == 1) ||
                            ($urandom_range(0, 19) == 0);
                send_sample(pick_sample(), first);
            end
            random_sent += phase_len;
            phase_count++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d samples, %0d series starts and %0d register writes over %0d phases,",
                 sent_count, start_count, cfg_write_count, phase_count);
        $display("window lengths from 0 to 127 in both modes; %0d results compared, %0d bad.",
                 checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS sliding_window_min_max");
        end else begin
            $display("FAIL sliding_window_min_max");
        end
        $finish;
    end

    // Result side. Each result gets a random wait before ready rises, with stretches of
    // no waiting at all, and once a long hold-off counted here.
    initial begin : result_receiver
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = out_fast ? 0 : $urandom_range(0, GAP_MAX);
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if ($urandom_range(0, 24) == 0)
                out_fast = !out_fast;
        end
    end

    // Ends a hung run: any transfer on any channel restarts the count.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles.", WATCHDOG_LIMIT);
        $display("FAIL sliding_window_min_max");
        $finish;
    end

endmodule
